FILE: rtl/core/sdh_pkg.sv
// sdh_pkg: shared types, widths and constants for the siren detector
// no dependencies; compiled first
package sdh_pkg;

    localparam int MAX_BATCH = 256;

    localparam int CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int SUM_W  = $clog2(MAX_BATCH) + 16;
    localparam int DIV_W  = SUM_W;
    localparam int DVS_W  = CNT_W;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] FREQ_LO   = 16'd500;
    localparam logic [15:0] FREQ_HI   = 16'd2000;
    localparam logic [15:0] FREQ_PEAK = 16'd1000;
    localparam logic [20:0] AMP20_MIN = 21'd98304;
    localparam logic [16:0] Q_ONE     = 17'd32768;
    localparam logic [15:0] RUN_MAX   = 16'hffff;
    localparam logic [CNT_W-1:0] BATCH_LIMIT = CNT_W'(MAX_BATCH);

    // 32768*s/1000 = 4096*s/125, taken as (s * FS_RCP) >> FS_RCP_SH, exact for s up to 1000
    localparam logic [22:0] FS_RCP    = 23'd4294968;
    localparam int          FS_RCP_SH = 17;
    // y/17 taken as (y * AS_RCP) >> AS_RCP_SH, exact for any 21-bit y
    localparam logic [21:0] AS_RCP    = 22'd3947581;
    localparam int          AS_RCP_SH = 26;

    localparam logic [15:0] THRESH_RST = 16'd16384;
    localparam logic [15:0] TRIG_RST   = 16'd3;
    localparam logic [15:0] CLEAR_RST  = 16'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FS,
        S_AS,
        S_ACC,
        S_CF_GO,
        S_CF_WAIT,
        S_JUDGE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic        vld;
        logic [15:0] conf;
    } t_judge;

    typedef struct packed {
        logic [15:0] thresh;
        logic [15:0] trig;
        logic [15:0] clear;
    } t_cfg;

endpackage

FILE: rtl/core/sdh_if.sv
// sdh_if: sample, result and config channel interfaces
// depends on sdh_pkg for the config index width
interface sdh_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] frequency;
    logic [15:0] amplitude;
    logic        last_in_batch;
    logic        empty_tick;

    modport source (output valid, frequency, amplitude, last_in_batch, empty_tick,
                    input ready);
    modport sink   (input valid, frequency, amplitude, last_in_batch, empty_tick,
                    output ready);
endinterface

interface sdh_result_if;
    logic        valid;
    logic        ready;
    logic        detected;
    logic [15:0] confidence;

    modport source (output valid, detected, confidence, input ready);
    modport sink   (input valid, detected, confidence, output ready);
endinterface

interface sdh_cfg_if import sdh_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sdh_div.sv
// sdh_div: restoring divider, one quotient bit per cycle
// depends on sdh_pkg (t_div_req, t_div_rsp, widths)
module sdh_div import sdh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt,  n_cnt;
    logic [DVS_W-1:0]  r_rem,  n_rem;
    logic [DIV_W-1:0]  r_quo,  n_quo;
    logic [DVS_W-1:0]  r_dvs,  n_dvs;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIV_W - 1);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // dividend bits shift out the top while quotient bits enter below
            n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

FILE: rtl/core/sdh_hyst.sv
// sdh_hyst: saturating high/low run counters and the detected flag
// depends on sdh_pkg (t_judge, t_cfg, RUN_MAX)
module sdh_hyst import sdh_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_judge i_judge,
    input  t_cfg   i_cfg,
    output logic   o_flag_next
);

    logic [15:0] r_high_run, n_high_run;
    logic [15:0] r_low_run,  n_low_run;
    logic        r_present,  n_present;

    logic is_high;

    assign is_high = i_judge.conf >= i_cfg.thresh;

    always_comb begin
        n_high_run = r_high_run;
        n_low_run  = r_low_run;
        n_present  = r_present;
        if (i_judge.vld) begin
            if (is_high) begin
                n_high_run = (r_high_run != RUN_MAX) ? r_high_run + 16'd1 : r_high_run;
                n_low_run  = '0;
                if (n_high_run >= i_cfg.trig) begin
                    n_present = 1'b1;
                end
            end else begin
                n_low_run  = (r_low_run != RUN_MAX) ? r_low_run + 16'd1 : r_low_run;
                n_high_run = '0;
                if (n_low_run >= i_cfg.clear) begin
                    n_present = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_run <= '0;
            r_low_run  <= '0;
            r_present  <= 1'b0;
        end else begin
            r_high_run <= n_high_run;
            r_low_run  <= n_low_run;
            r_present  <= n_present;
        end
    end

    assign o_flag_next = n_present;

endmodule

FILE: rtl/core/sdh_seq.sv
// sdh_seq: per-sample sequencer; scores samples, sums the batch and
// drives the divider; depends on sdh_pkg and sdh_sample_if
module sdh_seq import sdh_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sdh_sample_if.sink   i_sample,
    output t_div_req     o_div_req,
    input  t_div_rsp     i_div_rsp,
    input  logic         i_out_free,
    output t_judge       o_judge
);

    t_state r_state, n_state;

    logic [15:0]      r_freq, n_freq;
    logic [15:0]      r_amp,  n_amp;
    logic             r_last, n_last;
    logic [15:0]      r_fs,   n_fs;
    logic [15:0]      r_as,   n_as;
    logic [15:0]      r_conf, n_conf;
    logic [SUM_W-1:0] r_sum,  n_sum;
    logic [CNT_W-1:0] r_cnt,  n_cnt;

    logic        accept;
    logic [20:0] in_amp20;
    logic        in_qual;
    logic        room;
    logic [20:0] amp20;
    logic [15:0] dev;
    logic [9:0]  fs_span;
    logic [32:0] fs_prod;
    logic [20:0] as_num;
    logic [42:0] as_prod;
    logic [16:0] as_quo;
    logic [16:0] score2;

    assign accept   = i_sample.valid && i_sample.ready;
    assign in_amp20 = {1'b0, i_sample.amplitude, 4'b0} + {3'b0, i_sample.amplitude, 2'b0};
    assign in_qual  = (i_sample.frequency >= FREQ_LO) && (i_sample.frequency <= FREQ_HI)
                   && (in_amp20 >= AMP20_MIN);
    assign room     = r_cnt < BATCH_LIMIT;

    // latched sample is known to be in band here: deviation stays within 1000
    assign amp20   = {1'b0, r_amp, 4'b0} + {3'b0, r_amp, 2'b0};
    assign dev     = (r_freq >= FREQ_PEAK) ? r_freq - FREQ_PEAK : FREQ_PEAK - r_freq;
    assign fs_span = 10'(FREQ_PEAK - dev);
    assign fs_prod = 33'(fs_span) * 33'(FS_RCP);
    assign as_num  = amp20 - AMP20_MIN;
    assign as_prod = 43'(as_num) * 43'(AS_RCP);
    assign as_quo  = as_prod[AS_RCP_SH +: 17];
    assign score2  = {1'b0, r_fs} + {1'b0, r_as};

    assign i_sample.ready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sample.empty_tick) begin
                        n_state = S_JUDGE;
                    end else if (room && in_qual) begin
                        n_state = S_FS;
                    end else if (i_sample.last_in_batch) begin
                        n_state = S_CF_GO;
                    end
                end
            end
            S_FS:      n_state = S_AS;
            S_AS:      n_state = S_ACC;
            S_ACC:     n_state = r_last ? S_CF_GO : S_IDLE;
            S_CF_GO:   n_state = S_CF_WAIT;
            S_CF_WAIT: if (i_div_rsp.done) n_state = S_JUDGE;
            S_JUDGE:   if (i_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_freq = r_freq;
        n_amp  = r_amp;
        n_last = r_last;
        n_fs   = r_fs;
        n_as   = r_as;
        n_conf = r_conf;
        n_sum  = r_sum;
        n_cnt  = r_cnt;
        o_div_req = '0;
        o_judge   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_freq = i_sample.frequency;
                    n_amp  = i_sample.amplitude;
                    n_last = i_sample.last_in_batch;
                    if (i_sample.empty_tick) begin
                        n_sum  = '0;
                        n_cnt  = '0;
                        n_conf = '0;
                    end else if (room && !in_qual) begin
                        // zero score still counts toward the batch
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FS: begin
                n_fs = fs_prod[FS_RCP_SH +: 16];
            end
            S_AS: begin
                n_as = (as_quo > Q_ONE) ? Q_ONE[15:0] : as_quo[15:0];
            end
            S_ACC: begin
                n_sum = r_sum + SUM_W'(score2[16:1]);
                n_cnt = r_cnt + 1'b1;
            end
            S_CF_GO: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DIV_W'(r_sum);
                o_div_req.divisor  = DVS_W'(r_cnt);
            end
            S_CF_WAIT: begin
                if (i_div_rsp.done) n_conf = i_div_rsp.quot[15:0];
            end
            S_JUDGE: begin
                if (i_out_free) begin
                    o_judge.vld = 1'b1;
                    n_sum       = '0;
                    n_cnt       = '0;
                end
                o_judge.conf = r_conf;
            end
            default: begin
                n_sum = r_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_freq <= n_freq;
        r_amp  <= n_amp;
        r_last <= n_last;
        r_fs   <= n_fs;
        r_as   <= n_as;
        r_conf <= n_conf;
    end

endmodule

FILE: rtl/core/siren_detect_hysteresis.sv
// siren detector with hysteresis: an in-band sample is scored in steps (accept, two reciprocal
// multiplies, accumulate), and the next beat is taken only after the accumulate; an out-of-band
// sample is taken without scoring. a batch end adds the confidence divide on the one-bit-per-cycle
// divider and a judge step that waits until the result register is free; an empty tick goes
// straight to the judge step.
// reset is synchronous active low: sums, run counters and flag clear, threshold 16384, trigger 3, clear 3.
module siren_detect_hysteresis import sdh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdh_sample_if.sink    i_sample,
    sdh_result_if.source  o_result,
    sdh_cfg_if.sink       i_cfg
);

    t_cfg     r_cfg, n_cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_judge   judge;
    logic     flag_next;
    logic     out_free;

    logic        r_out_valid, n_out_valid;
    logic        r_out_det,   n_out_det;
    logic [15:0] r_out_conf,  n_out_conf;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_THRESH: n_cfg.thresh = i_cfg.data;
                CFG_TRIG:   n_cfg.trig   = i_cfg.data;
                CFG_CLEAR:  n_cfg.clear  = i_cfg.data;
                default:    n_cfg        = r_cfg;
            endcase
        end
    end

    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_det   = r_out_det;
        n_out_conf  = r_out_conf;
        if (o_result.ready) n_out_valid = 1'b0;
        if (judge.vld) begin
            n_out_valid = 1'b1;
            n_out_det   = flag_next;
            n_out_conf  = judge.conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh <= THRESH_RST;
            r_cfg.trig   <= TRIG_RST;
            r_cfg.clear  <= CLEAR_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_det  <= n_out_det;
        r_out_conf <= n_out_conf;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.detected   = r_out_det;
    assign o_result.confidence = r_out_conf;

    sdh_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .i_out_free (out_free),
        .o_judge    (judge)
    );

    sdh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sdh_hyst u_hyst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_judge     (judge),
        .i_cfg       (r_cfg),
        .o_flag_next (flag_next)
    );

endmodule

FILE: rtl/core/sdh_chk.sv
// sdh_chk: port-level checks on the siren detector, bound to the top level
// depends on siren_detect_hysteresis port names only
module sdh_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_detected,
    input logic [15:0] i_res_confidence,
    input logic        i_cfg_ready
);

    // confidence is an average of scores, never above one
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_confidence <= 16'd32768))
        else $error("confidence above 1.0");

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_detected) && $stable(i_res_confidence)))
        else $error("result beat changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind siren_detect_hysteresis sdh_chk u_sdh_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_result.valid),
    .i_res_ready      (o_result.ready),
    .i_res_detected   (o_result.detected),
    .i_res_confidence (o_result.confidence),
    .i_cfg_ready      (i_cfg.ready)
);
